@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/gbq_pkg.sv @@
// ---------------------------------------------------------------------------
// gbq_pkg
// Types, widths, filter coefficients and helpers of the gyro biquad core.
// ---------------------------------------------------------------------------
package gbq_pkg;

  // Number of axes, one filter lane each
  localparam int AXES = 3;

  localparam int RAW_W   = 16;
  localparam int SCALE_W = 10;
  localparam int BIAS_W  = 21;
  localparam int HIST_W  = 26;
  localparam int OUT_W   = 25;
  localparam int DIFF_W  = 28;  // raw * scale - bias before saturation
  localparam int COEF_W  = 32;
  localparam int PROD_W  = HIST_W + COEF_W;
  localparam int ACC_W   = 60;
  localparam int FRAC_W  = 30;  // Q2.30 coefficients

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 21;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_X = CFG_IDX_W'(1);
  localparam logic [SCALE_W-1:0]   SCALE_RST  = SCALE_W'(280);

  // Multiply-accumulate sequence: five taps, then a drain step
  localparam int MAC_TAPS = 5;
  localparam int MAC_K_W  = $clog2(MAC_TAPS + 1);
  localparam logic [MAC_K_W-1:0] TAP_U  = MAC_K_W'(0);
  localparam logic [MAC_K_W-1:0] TAP_X1 = MAC_K_W'(1);
  localparam logic [MAC_K_W-1:0] TAP_X2 = MAC_K_W'(2);
  localparam logic [MAC_K_W-1:0] TAP_Y1 = MAC_K_W'(3);
  localparam logic [MAC_K_W-1:0] TAP_Y2 = MAC_K_W'(4);
  localparam logic [MAC_K_W-1:0] TAP_LAST = MAC_K_W'(MAC_TAPS);

  // Q2.30 coefficients, feedback terms stored negated
  localparam logic signed [COEF_W-1:0] COEF_B0  = COEF_W'(713707878);
  localparam logic signed [COEF_W-1:0] COEF_B1  = COEF_W'(1427415756);
  localparam logic signed [COEF_W-1:0] COEF_B2  = COEF_W'(713707878);
  localparam logic signed [COEF_W-1:0] COEF_NA1 = COEF_W'(-1303095037);
  localparam logic signed [COEF_W-1:0] COEF_NA2 = COEF_W'(-477994647);

  localparam logic signed [DIFF_W-1:0] HIST_HI = DIFF_W'(33554431);
  localparam logic signed [DIFF_W-1:0] HIST_LO = DIFF_W'(-33554432);
  localparam logic signed [ACC_W-1:0]  OUT_HI  = ACC_W'(16777215);
  localparam logic signed [ACC_W-1:0]  OUT_LO  = ACC_W'(-16777215);
  localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

  typedef logic signed [HIST_W-1:0] hist_t;
  typedef logic signed [OUT_W-1:0]  rate_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DONE
  } state_t;

  // Sequencer to lane control group
  typedef struct packed {
    logic               load_u;   // capture scaled input word
    logic               mac_mul;  // form product of tap mac_k
    logic               mac_acc;  // add previous product
    logic [MAC_K_W-1:0] mac_k;
    logic               commit;   // result leaves, histories shift
    logic               primed;
  } lane_ctl_t;

  function automatic logic signed [COEF_W-1:0] coef_sel(logic [MAC_K_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    unique case (k)
      TAP_U:   c = COEF_B0;
      TAP_X1:  c = COEF_B1;
      TAP_X2:  c = COEF_B2;
      TAP_Y1:  c = COEF_NA1;
      TAP_Y2:  c = COEF_NA2;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic hist_t sat_hist(logic signed [DIFF_W-1:0] v);
    hist_t r;
    if (v > HIST_HI)      r = HIST_HI[HIST_W-1:0];
    else if (v < HIST_LO) r = HIST_LO[HIST_W-1:0];
    else                  r = v[HIST_W-1:0];
    return r;
  endfunction

  function automatic rate_t sat_out(logic signed [ACC_W-1:0] v);
    rate_t r;
    if (v > OUT_HI)      r = OUT_HI[OUT_W-1:0];
    else if (v < OUT_LO) r = OUT_LO[OUT_W-1:0];
    else                 r = v[OUT_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/core/gbq_lane.sv @@
// ---------------------------------------------------------------------------
// gbq_lane
// One axis: scale and bias, direct form I biquad on a shared multiplier.
// ---------------------------------------------------------------------------
module gbq_lane
  import gbq_pkg::*;
(
  input  logic                      clk,
  input  lane_ctl_t                 ctl,
  input  logic signed [RAW_W-1:0]   raw,
  input  logic [SCALE_W-1:0]        scale,
  input  logic signed [BIAS_W-1:0]  bias,
  output rate_t                     y
);

  hist_t u_r, x1_r, x2_r, y1_r, y2_r;
  logic signed [PROD_W-1:0] p_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [DIFF_W-1:0] diff;
  hist_t                    op;
  logic signed [ACC_W-1:0]  q;
  rate_t                    y_filt;

  // scaled, bias-corrected input word
  assign diff = DIFF_W'(raw * $signed({1'b0, scale})) - DIFF_W'(bias);

  // tap operand
  always_comb begin
    unique case (ctl.mac_k)
      TAP_U:   op = u_r;
      TAP_X1:  op = x1_r;
      TAP_X2:  op = x2_r;
      TAP_Y1:  op = y1_r;
      TAP_Y2:  op = y2_r;
      default: op = u_r;
    endcase
  end

  // round half up at Q30, then clamp; first word passes through
  assign q      = (acc_r + RND_HALF) >>> FRAC_W;
  assign y_filt = sat_out(q);
  assign y      = ctl.primed ? y_filt : sat_out(ACC_W'(u_r));

  // input word, product and accumulator
  always_ff @(posedge clk) begin
    if (ctl.load_u) begin
      u_r   <= sat_hist(diff);
      acc_r <= '0;
    end else if (ctl.mac_acc) begin
      acc_r <= acc_r + ACC_W'(p_r);
    end
    if (ctl.mac_mul) begin
      p_r <= PROD_W'(op * coef_sel(ctl.mac_k));
    end
  end

  // history shift on commit; priming fills both taps
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      x1_r <= u_r;
      y1_r <= HIST_W'(y);
      if (ctl.primed) begin
        x2_r <= x1_r;
        y2_r <= y1_r;
      end else begin
        x2_r <= u_r;
        y2_r <= HIST_W'(y);
      end
    end
  end

endmodule

@@ rtl/core/gbq_ctrl.sv @@
// ---------------------------------------------------------------------------
// gbq_ctrl
// Sequencer: accepts a word, steps the lanes through the taps, commits.
// ---------------------------------------------------------------------------
module gbq_ctrl
  import gbq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      merge_free,
  output lane_ctl_t ctl
);

  state_t             state_r, state_nxt;
  logic [MAC_K_W-1:0] k_r, k_nxt;
  logic               primed_r, primed_nxt;
  logic               accept;

  assign accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    primed_nxt = primed_r;
    unique case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        if (accept) state_nxt = ST_MAC;
      end
      ST_MAC: begin
        k_nxt = k_r + MAC_K_W'(1);
        if (k_r == TAP_LAST) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (merge_free) begin
          state_nxt  = ST_IDLE;
          primed_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    ctl.load_u  = accept;
    ctl.mac_mul = (state_r == ST_MAC) && (k_r != TAP_LAST);
    ctl.mac_acc = (state_r == ST_MAC) && (k_r != TAP_U);
    ctl.mac_k   = k_r;
    ctl.commit  = (state_r == ST_DONE) && merge_free;
    ctl.primed  = primed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      k_r      <= '0;
      primed_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      primed_r <= primed_nxt;
    end
  end

endmodule

@@ rtl/core/gbq_merge.sv @@
// ---------------------------------------------------------------------------
// gbq_merge
// Gathers the lane results into the output word register.
// ---------------------------------------------------------------------------
module gbq_merge
  import gbq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  commit,
  input  rate_t lane_y [AXES],
  output logic  merge_free,
  output logic  out_valid,
  input  logic  out_ready,
  output rate_t out_roll_rate,
  output rate_t out_pitch_rate,
  output rate_t out_yaw_rate
);

  logic  valid_r;
  rate_t roll_r, pitch_r, yaw_r;

  // free when empty or being drained this cycle
  assign merge_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (commit) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // x, y, z lanes map to roll, pitch, yaw
  always_ff @(posedge clk) begin
    if (commit) begin
      roll_r  <= lane_y[0];
      pitch_r <= lane_y[1];
      yaw_r   <= lane_y[2];
    end
  end

  assign out_valid      = valid_r;
  assign out_roll_rate  = roll_r;
  assign out_pitch_rate = pitch_r;
  assign out_yaw_rate   = yaw_r;

endmodule

@@ rtl/core/three_axis_gyro_biquad_core.sv @@
// ---------------------------------------------------------------------------
// three_axis_gyro_biquad_core
// Gyro rate conditioner: scale, bias removal and 2nd-order low-pass per axis.
// ---------------------------------------------------------------------------
// Usage:
//  - in_ channel: one word of three raw 16-bit counts (x, y, z).
//  - out_ channel: one word of three filtered 25-bit rates (roll, pitch, yaw)
//    in quarter millidegrees per second, saturated, per input word.
//  - cfg_ channel: index 0 scale_per_count, 1..3 bias x/y/z; other indexes
//    are dropped. cfg_ready is always high; write only while idle.
//  - An accepted word runs through the tap states and is then committed to the
//    output register. Each axis has its own lane whose single 26x32 multiplier
//    walks the five taps in turn; no new word is taken until it is committed.
//  - The output register holds one finished word, so the next input is taken
//    while it waits. If the receiver stalls, the following word finishes and
//    then waits in its lane until the register drains.
//  - Reset clears configuration to defaults and the primed flag; the first
//    word after reset passes through unfiltered and seeds the histories.
// ---------------------------------------------------------------------------
module three_axis_gyro_biquad_core
  import gbq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [RAW_W-1:0] in_raw_x,
  input  logic signed [RAW_W-1:0] in_raw_y,
  input  logic signed [RAW_W-1:0] in_raw_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rate_t                   out_roll_rate,
  output rate_t                   out_pitch_rate,
  output rate_t                   out_yaw_rate,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [SCALE_W-1:0]       scale_r;
  logic signed [BIAS_W-1:0] bias_r [AXES];
  logic signed [RAW_W-1:0]  raw [AXES];
  rate_t                    lane_y [AXES];
  lane_ctl_t                ctl;
  logic                     merge_free;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RST;
      for (int a = 0; a < AXES; a++) bias_r[a] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SCALE) scale_r <= cfg_data[SCALE_W-1:0];
      for (int a = 0; a < AXES; a++) begin
        if (cfg_index == CFG_BIAS_X + CFG_IDX_W'(a)) bias_r[a] <= cfg_data[BIAS_W-1:0];
      end
    end
  end

  assign raw[0] = in_raw_x;
  assign raw[1] = in_raw_y;
  assign raw[2] = in_raw_z;

  gbq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .merge_free (merge_free),
    .ctl        (ctl)
  );

  // one filter lane per axis
  for (genvar g = 0; g < AXES; g++) begin : g_lane
    gbq_lane u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .raw   (raw[g]),
      .scale (scale_r),
      .bias  (bias_r[g]),
      .y     (lane_y[g])
    );
  end

  gbq_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .commit         (ctl.commit),
    .lane_y         (lane_y),
    .merge_free     (merge_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_roll_rate  (out_roll_rate),
    .out_pitch_rate (out_pitch_rate),
    .out_yaw_rate   (out_yaw_rate)
  );

endmodule

@@ rtl/core/gbq_checker.sv @@
// ---------------------------------------------------------------------------
// gbq_checker
// Port-level checks of the gyro biquad core, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gbq_checker
  import gbq_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input rate_t                   out_roll_rate,
  input rate_t                   out_pitch_rate,
  input rate_t                   out_yaw_rate
);

  // a pending output word stays until taken
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "out word dropped while stalled")

  // a stalled output word keeps its payload
  `ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable(out_roll_rate) && $stable(out_pitch_rate) && $stable(out_yaw_rate), "out word changed while stalled")

  // after an accepted word, in_ready is checked low once, in the done state
  `ASSERT_CLK(a_busy, in_valid && in_ready |-> ##7 !in_ready, "input taken during tap sequence")

  // no output word right after reset
  `ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "out_valid set after reset")

endmodule

bind three_axis_gyro_biquad_core gbq_checker u_gbq_checker (.*);
